### rtl/core/triangle_cull_and_project_core_assert.svh
// Assertion helpers used by the core's edge output module
`ifndef TRIANGLE_CULL_AND_PROJECT_CORE_ASSERT_SVH
`define TRIANGLE_CULL_AND_PROJECT_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TCP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tcp: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define TCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tcp: next-cycle check failed");

`endif

### rtl/core/tcp_pkg.sv
package tcp_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int OUT_W = 16;
	localparam int DIM_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int NVTX = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CULL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST = 13'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

	// Projection datapath widths
	localparam int SUM_W = COORD_W + 1;
	localparam int NUM_W = 38;
	localparam int NMAG_W = NUM_W - 1;
	localparam int DMAG_W = COORD_W + 1;
	localparam int QUO_W = OUT_W;
	localparam int REM_W = DMAG_W + QUO_W;
	localparam int STEPS_PER_STAGE = 2;
	localparam int ITER_STAGES = QUO_W / STEPS_PER_STAGE;

	// Pipeline depths: lane front end, divider set-up, iterations, final fix-up
	localparam int LANE_FRONT = 2;
	localparam int PIPE_DEPTH = LANE_FRONT + 2 + ITER_STAGES + 1;
	localparam int CULL_DEPTH = 5;

	// Edge sequencing
	localparam int EDGE_IDX_W = 2;
	localparam logic [EDGE_IDX_W-1:0] EDGE_FIRST = 2'd0;
	localparam logic [EDGE_IDX_W-1:0] EDGE_LAST = 2'd2;

	localparam logic signed [OUT_W-1:0] PIX_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] PIX_MIN = 16'sh8000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [OUT_W-1:0] pix_t;

	typedef struct packed {
		logic neg;
		logic zd;
		logic npos;
		logic nneg;
		logic big;
	} div_ctl_t;

endpackage

### rtl/core/tcp_in_if.sv
interface tcp_in_if;
	import tcp_pkg::*;

	logic valid;
	logic ready;
	coord_t a_x;
	coord_t a_y;
	coord_t a_z;
	coord_t b_x;
	coord_t b_y;
	coord_t b_z;
	coord_t c_x;
	coord_t c_y;
	coord_t c_z;

	modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input ready);
	modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready);
endinterface

### rtl/core/tcp_out_if.sv
interface tcp_out_if;
	import tcp_pkg::*;

	logic valid;
	logic ready;
	pix_t start_x;
	pix_t start_y;
	pix_t end_x;
	pix_t end_y;
	logic last_edge;

	modport source (output valid, start_x, start_y, end_x, end_y, last_edge,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, last_edge,
		output ready);
endinterface

### rtl/core/tcp_cfg_if.sv
interface tcp_cfg_if;
	import tcp_pkg::*;

	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/tcp_cull.sv
module tcp_cull (
	input logic clk,
	input logic adv,
	input logic cull_en,
	input tcp_pkg::coord_t va [tcp_pkg::NVTX],
	input tcp_pkg::coord_t vb [tcp_pkg::NVTX],
	input tcp_pkg::coord_t vc [tcp_pkg::NVTX],
	output logic keep
);
	import tcp_pkg::*;

	localparam int PROD_W = 2 * SUM_W;
	localparam int NRM_W = PROD_W + 1;
	localparam int SPLIT = COORD_W;
	localparam int HI_W = NRM_W - SPLIT;
	localparam int HP_W = HI_W + COORD_W;
	localparam int LP_W = SPLIT + 1 + COORD_W;
	localparam int HSUM_W = HP_W + 2;
	localparam int LSUM_W = LP_W + 2;
	localparam int TOT_W = HSUM_W + SPLIT + 2;
	localparam int DLY = PIPE_DEPTH - CULL_DEPTH;

	logic signed [SUM_W-1:0] u_s1 [NVTX];
	logic signed [SUM_W-1:0] v_s1 [NVTX];
	coord_t a_s1 [NVTX];
	coord_t a_s2 [NVTX];
	coord_t a_s3 [NVTX];
	logic signed [PROD_W-1:0] prod_s2 [6];
	logic signed [NRM_W-1:0] n_s3 [NVTX];
	logic signed [HP_W-1:0] hp_s4 [NVTX];
	logic signed [LP_W-1:0] lp_s4 [NVTX];
	logic keep_s5;
	logic keep_dly [DLY];

	logic signed [HSUM_W-1:0] hsum;
	logic signed [LSUM_W-1:0] lsum;
	logic signed [TOT_W-1:0] total;

	// Edge vectors from the first vertex
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NVTX; i++) begin
				u_s1[i] <= SUM_W'(vb[i]) - SUM_W'(va[i]);
				v_s1[i] <= SUM_W'(vc[i]) - SUM_W'(va[i]);
				a_s1[i] <= va[i];
			end
		end
	end

	// Cross-product terms
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2[0] <= u_s1[1] * v_s1[2];
			prod_s2[1] <= u_s1[2] * v_s1[1];
			prod_s2[2] <= u_s1[2] * v_s1[0];
			prod_s2[3] <= u_s1[0] * v_s1[2];
			prod_s2[4] <= u_s1[0] * v_s1[1];
			prod_s2[5] <= u_s1[1] * v_s1[0];
			a_s2 <= a_s1;
		end
	end

	// Normal
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NVTX; i++) begin
				n_s3[i] <= NRM_W'(prod_s2[2*i]) - NRM_W'(prod_s2[2*i+1]);
			end
			a_s3 <= a_s2;
		end
	end

	// Dot product, normal split into high and low parts
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NVTX; i++) begin
				hp_s4[i] <= $signed(n_s3[i][NRM_W-1:SPLIT]) * a_s3[i];
				lp_s4[i] <= $signed({1'b0, n_s3[i][SPLIT-1:0]}) * a_s3[i];
			end
		end
	end

	// Recombine and take the exact sign
	always_comb begin
		hsum = HSUM_W'(hp_s4[0]) + HSUM_W'(hp_s4[1]) + HSUM_W'(hp_s4[2]);
		lsum = LSUM_W'(lp_s4[0]) + LSUM_W'(lp_s4[1]) + LSUM_W'(lp_s4[2]);
		total = (TOT_W'(hsum) <<< SPLIT) + TOT_W'(lsum);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep_s5 <= !cull_en || (!total[TOT_W-1] && (total != '0));
		end
	end

	// Align the decision with the projection lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			keep_dly[0] <= keep_s5;
			for (int i = 1; i < DLY; i++) begin
				keep_dly[i] <= keep_dly[i-1];
			end
		end
	end

	assign keep = keep_dly[DLY-1];

endmodule

### rtl/core/tcp_div.sv
module tcp_div (
	input logic clk,
	input logic adv,
	input logic signed [tcp_pkg::NUM_W-1:0] num,
	input tcp_pkg::coord_t den,
	output tcp_pkg::pix_t quo
);
	import tcp_pkg::*;

	logic [NMAG_W-1:0] nmag_s1;
	logic [DMAG_W-1:0] dmag_s1;
	div_ctl_t ctl_s1;
	div_ctl_t ctl_c;
	logic [COORD_W-1:0] zabs;

	// Iteration stages; entry 0 is the set-up stage
	logic [REM_W-1:0] rem_s [ITER_STAGES+1];
	logic [QUO_W-1:0] quo_s [ITER_STAGES+1];
	logic [DMAG_W-1:0] dmag_s [ITER_STAGES+1];
	div_ctl_t ctl_s [ITER_STAGES+1];

	logic [QUO_W-1:0] qf;
	logic [QUO_W:0] qneg;
	logic rnz;
	div_ctl_t cf;
	pix_t res;
	pix_t res_sf;

	assign zabs = den[COORD_W-1] ? COORD_W'(-den) : COORD_W'(den);

	// Sign and magnitude
	always_ff @(posedge clk) begin
		if (adv) begin
			nmag_s1 <= num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
			dmag_s1 <= {zabs, 1'b0};
			ctl_s1.neg <= num[NUM_W-1] ^ den[COORD_W-1];
			ctl_s1.zd <= (den == '0);
			ctl_s1.npos <= !num[NUM_W-1] && (num != '0);
			ctl_s1.nneg <= num[NUM_W-1];
			ctl_s1.big <= 1'b0;
		end
	end

	// Flag quotients too large for the iteration
	always_comb begin
		ctl_c = ctl_s1;
		ctl_c.big = REM_W'(nmag_s1) >= {dmag_s1, {QUO_W{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= REM_W'(nmag_s1);
			quo_s[0] <= '0;
			dmag_s[0] <= dmag_s1;
			ctl_s[0] <= ctl_c;
		end
	end

	// Restoring division, two quotient bits a stage
	for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
		logic [REM_W-1:0] r;
		logic [QUO_W-1:0] q;
		logic [REM_W-1:0] t;

		always_comb begin
			r = rem_s[k];
			q = quo_s[k];
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				t = REM_W'(dmag_s[k]) << (QUO_W - 1 - (k * STEPS_PER_STAGE + j));
				if (r >= t) begin
					r = r - t;
					q = q | (QUO_W'(1) << (QUO_W - 1 - (k * STEPS_PER_STAGE + j)));
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= r;
				quo_s[k+1] <= q;
				dmag_s[k+1] <= dmag_s[k];
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	// Floor toward minus infinity and saturate
	always_comb begin
		qf = quo_s[ITER_STAGES];
		cf = ctl_s[ITER_STAGES];
		rnz = (rem_s[ITER_STAGES] != '0);
		qneg = {1'b0, qf} + (QUO_W+1)'(rnz);
		if (cf.zd) begin
			res = cf.npos ? PIX_MAX : (cf.nneg ? PIX_MIN : '0);
		end else if (cf.big) begin
			res = cf.neg ? PIX_MIN : PIX_MAX;
		end else if (!cf.neg) begin
			res = qf[QUO_W-1] ? PIX_MAX : $signed(qf);
		end else begin
			res = (qneg > (QUO_W+1)'(1 << (QUO_W - 1))) ? PIX_MIN : $signed(OUT_W'(-qneg));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_sf <= res;
		end
	end

	assign quo = res_sf;

endmodule

### rtl/core/tcp_lane.sv
module tcp_lane (
	input logic clk,
	input logic adv,
	input tcp_pkg::coord_t x,
	input tcp_pkg::coord_t y,
	input tcp_pkg::coord_t z,
	input logic [tcp_pkg::DIM_W-1:0] width,
	input logic [tcp_pkg::DIM_W-1:0] height,
	output tcp_pkg::pix_t sx,
	output tcp_pkg::pix_t sy
);
	import tcp_pkg::*;

	logic signed [SUM_W-1:0] xs_s1;
	logic signed [SUM_W-1:0] ys_s1;
	coord_t z_s1;
	logic signed [NUM_W-1:0] xn_s2;
	logic signed [NUM_W-1:0] yn_s2;
	coord_t z_s2;

	// Numerator sums
	always_ff @(posedge clk) begin
		if (adv) begin
			xs_s1 <= SUM_W'(z) + SUM_W'(x);
			ys_s1 <= SUM_W'(z) - SUM_W'(y);
			z_s1 <= z;
		end
	end

	// Scale by the screen size
	always_ff @(posedge clk) begin
		if (adv) begin
			xn_s2 <= NUM_W'($signed({1'b0, width}) * xs_s1);
			yn_s2 <= NUM_W'($signed({1'b0, height}) * ys_s1);
			z_s2 <= z_s1;
		end
	end

	tcp_div u_div_x (
		.clk(clk),
		.adv(adv),
		.num(xn_s2),
		.den(z_s2),
		.quo(sx)
	);

	tcp_div u_div_y (
		.clk(clk),
		.adv(adv),
		.num(yn_s2),
		.den(z_s2),
		.quo(sy)
	);

endmodule

### rtl/core/tcp_edge_out.sv
`include "triangle_cull_and_project_core_assert.svh"

module tcp_edge_out (
	input logic clk,
	input logic arst_n,
	input logic ld,
	input tcp_pkg::pix_t sx [tcp_pkg::NVTX],
	input tcp_pkg::pix_t sy [tcp_pkg::NVTX],
	output logic free,
	tcp_out_if.source edge_out
);
	import tcp_pkg::*;

	pix_t px_q [NVTX];
	pix_t py_q [NVTX];
	logic busy_q;
	logic [EDGE_IDX_W-1:0] cnt_q;
	logic [EDGE_IDX_W-1:0] nxt;
	logic take;
	logic at_last;

	assign at_last = (cnt_q == EDGE_LAST);
	assign take = edge_out.valid && edge_out.ready;
	assign free = !busy_q || (take && at_last);
	assign nxt = at_last ? EDGE_FIRST : cnt_q + 2'd1;

	// Hold the projected vertices of the triangle in flight
	always_ff @(posedge clk) begin
		if (ld) begin
			px_q <= sx;
			py_q <= sy;
		end
	end

	// Step through the triangle's edges in order, first to last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= EDGE_FIRST;
		end else if (ld) begin
			busy_q <= 1'b1;
			cnt_q <= EDGE_FIRST;
		end else if (take) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= nxt;
		end
	end

	assign edge_out.valid = busy_q;
	assign edge_out.start_x = px_q[cnt_q];
	assign edge_out.start_y = py_q[cnt_q];
	assign edge_out.end_x = px_q[nxt];
	assign edge_out.end_y = py_q[nxt];
	assign edge_out.last_edge = at_last;

	`TCP_ASSERT_NEXT(a_load_starts, clk, arst_n, ld, busy_q && (cnt_q == EDGE_FIRST))
	`TCP_ASSERT_NEXT(a_last_frees, clk, arst_n, take && at_last && !ld, !busy_q)
	`TCP_ASSERT_IMPL(a_mid_blocks, clk, arst_n, busy_q && !at_last, !free && !ld)
	`TCP_ASSERT_IMPL(a_cnt_range, clk, arst_n, busy_q, cnt_q != 2'd3)

endmodule

### rtl/core/triangle_cull_and_project_core.sv
// Back-face culling and perspective projection of one triangle.
// tri_in: one beat carries three camera-space vertices (24-bit signed each).
// edge_out: a kept triangle yields three beats, edges A-B, B-C and C-A, the
//   last one flagged by last_edge; a culled triangle yields none.
// cfg: register writes (culling enable, screen width, screen height), always
//   ready; write only while no triangle is in flight.
// Pipeline: an accepted triangle reaches its first edge beat through a
//   13-stage pipeline of three vertex lanes (each with two pipelined
//   restoring dividers, two quotient bits a stage) beside a 5-stage exact
//   normal test, then the edge register.
// Throughput: one triangle a cycle enters while the pipeline advances; the
//   edge register sends one edge a cycle while edge_out is ready.
// Stalls: a kept triangle waiting on a busy edge register freezes the whole
//   pipeline and drops tri_in ready; a new triangle is taken as the last edge leaves.
// Reset: arst_n clears the pipeline valids and the edge register and loads
//   culling off, width 640 and height 480.
module triangle_cull_and_project_core (
	input logic clk,
	input logic arst_n,
	tcp_in_if.sink tri_in,
	tcp_out_if.source edge_out,
	tcp_cfg_if.sink cfg
);
	import tcp_pkg::*;

	logic cull_en_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic vld_s [PIPE_DEPTH];
	logic adv;
	logic keep;
	logic free;
	logic ld;
	coord_t va [NVTX];
	coord_t vb [NVTX];
	coord_t vc [NVTX];
	pix_t sx [NVTX];
	pix_t sy [NVTX];

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_en_q <= 1'b0;
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CULL: cull_en_q <= cfg.data[0];
				REG_WIDTH: width_q <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless a kept triangle waits on a busy edge register
	assign adv = !vld_s[PIPE_DEPTH-1] || !keep || free;
	assign ld = vld_s[PIPE_DEPTH-1] && keep && free;
	assign tri_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= tri_in.valid;
			for (int i = 1; i < PIPE_DEPTH; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign va = '{tri_in.a_x, tri_in.a_y, tri_in.a_z};
	assign vb = '{tri_in.b_x, tri_in.b_y, tri_in.b_z};
	assign vc = '{tri_in.c_x, tri_in.c_y, tri_in.c_z};

	tcp_cull u_cull (
		.clk(clk),
		.adv(adv),
		.cull_en(cull_en_q),
		.va(va),
		.vb(vb),
		.vc(vc),
		.keep(keep)
	);

	tcp_lane u_lane_a (
		.clk(clk), .adv(adv),
		.x(tri_in.a_x), .y(tri_in.a_y), .z(tri_in.a_z),
		.width(width_q), .height(height_q),
		.sx(sx[0]), .sy(sy[0])
	);

	tcp_lane u_lane_b (
		.clk(clk), .adv(adv),
		.x(tri_in.b_x), .y(tri_in.b_y), .z(tri_in.b_z),
		.width(width_q), .height(height_q),
		.sx(sx[1]), .sy(sy[1])
	);

	tcp_lane u_lane_c (
		.clk(clk), .adv(adv),
		.x(tri_in.c_x), .y(tri_in.c_y), .z(tri_in.c_z),
		.width(width_q), .height(height_q),
		.sx(sx[2]), .sy(sy[2])
	);

	tcp_edge_out u_edge_out (
		.clk(clk),
		.arst_n(arst_n),
		.ld(ld),
		.sx(sx),
		.sy(sy),
		.free(free),
		.edge_out(edge_out)
	);

endmodule

### sim/triangle_cull_and_project_core_tb.sv
module triangle_cull_and_project_core_tb;
	import tcp_pkg::*;

	typedef struct {
		pix_t start_x;
		pix_t start_y;
		pix_t end_x;
		pix_t end_y;
		logic last_edge;
	} edge_beat_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	logic clk;
	logic arst_n;

	tcp_in_if tri_in ();
	tcp_out_if edge_out ();
	tcp_cfg_if cfg ();

	triangle_cull_and_project_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.tri_in(tri_in),
		.edge_out(edge_out),
		.cfg(cfg)
	);

	// Shadow registers of the block
	logic cull_on;
	logic [DIM_W-1:0] scr_w;
	logic [DIM_W-1:0] scr_h;

	edge_beat_t pending_edges[$];
	int err_count = 0;
	int beats_seen = 0;
	bit stall_en = 0;
	int stall_left = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH beat %0d: %s", beats_seen, what);
		err_count++;
	endtask

	// Exact sign of ((B-A) x (C-A)) . A
	function automatic bit faces_viewer(vertex_t a, vertex_t b, vertex_t c);
		longint ux, uy, uz, vx, vy, vz;
		logic signed [79:0] nx, ny, nz, ax, ay, az, dot;
		ux = b.x - a.x; uy = b.y - a.y; uz = b.z - a.z;
		vx = c.x - a.x; vy = c.y - a.y; vz = c.z - a.z;
		nx = uy * vz - uz * vy;
		ny = uz * vx - ux * vz;
		nz = ux * vy - uy * vx;
		ax = a.x; ay = a.y; az = a.z;
		dot = nx * ax + ny * ay + nz * az;
		return dot > 0;
	endfunction

	// floor(num / (2z)), saturated; zero depth goes by the sign of zsgn
	function automatic pix_t pixel_of(longint num, longint z, longint zsgn);
		longint d, q;
		if (z == 0) begin
			if (zsgn > 0) return PIX_MAX;
			if (zsgn < 0) return PIX_MIN;
			return '0;
		end
		d = 2 * z;
		if (d < 0) begin
			d = -d;
			num = -num;
		end
		q = num / d;
		if (num % d != 0 && num < 0) q--;
		if (q > 32767) return PIX_MAX;
		if (q < -32768) return PIX_MIN;
		return pix_t'(q);
	endfunction

	task automatic predict_edges(input vertex_t v[3]);
		pix_t sx[3], sy[3];
		longint w, h, x, y, z;
		edge_beat_t e;
		w = scr_w;
		h = scr_h;
		if (cull_on && !faces_viewer(v[0], v[1], v[2])) return;
		for (int i = 0; i < 3; i++) begin
			x = v[i].x; y = v[i].y; z = v[i].z;
			sx[i] = pixel_of(w * (z + x), z, w * x);
			sy[i] = pixel_of(h * (z - y), z, -h * y);
		end
		for (int i = 0; i < 3; i++) begin
			e.start_x = sx[i];
			e.start_y = sy[i];
			e.end_x = sx[(i + 1) % 3];
			e.end_y = sy[(i + 1) % 3];
			e.last_edge = (i == 2);
			pending_edges.push_back(e);
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
		return $urandom_range(5, 25);
	endfunction

	// Send one triangle and hold until it is taken
	task automatic send_triangle(input vertex_t v[3], input bit idle_after = 1);
		int gap;
		tri_in.valid <= 1'b1;
		tri_in.a_x <= v[0].x; tri_in.a_y <= v[0].y; tri_in.a_z <= v[0].z;
		tri_in.b_x <= v[1].x; tri_in.b_y <= v[1].y; tri_in.b_z <= v[1].z;
		tri_in.c_x <= v[2].x; tri_in.c_y <= v[2].y; tri_in.c_z <= v[2].z;
		do @(posedge clk); while (!tri_in.ready);
		predict_edges(v);
		gap = idle_after ? gap_len() : 0;
		if (gap > 0) begin
			tri_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		int guard = 0;
		if (tri_in.valid) begin
			tri_in.valid <= 1'b0;
			@(posedge clk);
		end
		while (pending_edges.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		// let a culled triangle still in the pipe fall out
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_CULL: cull_on = val[0];
			REG_WIDTH: scr_w = val;
			REG_HEIGHT: scr_h = val;
			default: ;
		endcase
	endtask

	function automatic coord_t rand_coord(bit is_depth);
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom);
			1: return $urandom_range(0, 1) ? coord_t'(24'sh7fffff) : coord_t'(24'sh800000);
			2: return is_depth ? coord_t'(0) : coord_t'($urandom_range(0, 8191) - 4096);
			default: return coord_t'(int'($urandom_range(0, 400000)) - 200000);
		endcase
	endfunction

	function automatic vertex_t mk(int x, int y, int z);
		vertex_t v;
		v.x = coord_t'(x); v.y = coord_t'(y); v.z = coord_t'(z);
		return v;
	endfunction

	task automatic send_random(input int n);
		vertex_t v[3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				v[i].x = rand_coord(0);
				v[i].y = rand_coord(0);
				v[i].z = rand_coord(1);
			end
			send_triangle(v);
		end
	endtask

	// Check each edge beat against the oldest prediction
	always @(posedge clk) begin
		edge_beat_t e;
		if (arst_n && edge_out.valid && edge_out.ready) begin
			beats_seen++;
			if (pending_edges.size() == 0) begin
				report_mismatch("edge beat with nothing predicted");
			end else begin
				e = pending_edges.pop_front();
				if (edge_out.start_x !== e.start_x)
					report_mismatch($sformatf("start_x %0d want %0d", edge_out.start_x, e.start_x));
				if (edge_out.start_y !== e.start_y)
					report_mismatch($sformatf("start_y %0d want %0d", edge_out.start_y, e.start_y));
				if (edge_out.end_x !== e.end_x)
					report_mismatch($sformatf("end_x %0d want %0d", edge_out.end_x, e.end_x));
				if (edge_out.end_y !== e.end_y)
					report_mismatch($sformatf("end_y %0d want %0d", edge_out.end_y, e.end_y));
				if (edge_out.last_edge !== e.last_edge)
					report_mismatch($sformatf("last_edge %0b want %0b", edge_out.last_edge,
						e.last_edge));
			end
		end
	end

	// Hold off the edge side at random, short stalls mostly
	always @(posedge clk) begin
		if (!stall_en) begin
			edge_out.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			edge_out.ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= gap_len();
			edge_out.ready <= 1'b0;
		end else begin
			edge_out.ready <= 1'b1;
		end
	end

	task automatic test_reset_defaults();
		vertex_t v[3];
		v[0] = mk(4096, 4096, 8192);
		v[1] = mk(-4096, 0, 16384);
		v[2] = mk(0, -4096, 4096);
		send_triangle(v);
		// back-facing one passes too while culling is off
		v[0] = mk(0, 0, 4096); v[1] = mk(0, 4096, 4096); v[2] = mk(4096, 0, 4096);
		send_triangle(v);
	endtask

	task automatic test_zero_depth();
		vertex_t v[3];
		v[0] = mk(4096, -4096, 0);
		v[1] = mk(-4096, 4096, 0);
		v[2] = mk(0, 0, 0);
		send_triangle(v);
		v[0] = mk(1, 1, -1); v[1] = mk(-1, -1, 1); v[2] = mk(5, -3, 2);
		send_triangle(v);
	endtask

	task automatic test_extremes();
		vertex_t v[3];
		v[0] = mk(8388607, 8388607, 8388607);
		v[1] = mk(-8388608, -8388608, -8388608);
		v[2] = mk(8388607, -8388608, 1);
		send_triangle(v);
		v[0] = mk(-8388608, 8388607, -1);
		v[1] = mk(8388607, -8388608, 8388607);
		v[2] = mk(-8388608, -8388608, -8388608);
		send_triangle(v);
		v[0] = mk(-1, -1, -1); v[1] = mk(0, 0, 0); v[2] = mk(1, 1, 1);
		send_triangle(v);
	endtask

	task automatic test_culling();
		vertex_t v[3];
		write_reg(REG_CULL, 13'd1);
		// kept, dropped, then flat (normal zero) dropped
		v[0] = mk(0, 0, 4096); v[1] = mk(4096, 0, 4096); v[2] = mk(0, 4096, 4096);
		send_triangle(v);
		v[0] = mk(0, 0, 4096); v[1] = mk(0, 4096, 4096); v[2] = mk(4096, 0, 4096);
		send_triangle(v);
		v[0] = mk(0, 0, 4096); v[1] = mk(4096, 0, 4096); v[2] = mk(8192, 0, 4096);
		send_triangle(v);
		v[0] = mk(8388607, -8388608, 8388607);
		v[1] = mk(-8388608, 8388607, -8388608);
		v[2] = mk(8388607, 8388607, -8388608);
		send_triangle(v);
		send_random(20);
		write_reg(REG_CULL, 13'd0);
	endtask

	task automatic test_sizes();
		logic [DIM_W-1:0] sizes[6] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd1920, 13'd7};
		for (int i = 0; i < 6; i++) begin
			write_reg(REG_WIDTH, sizes[i]);
			write_reg(REG_HEIGHT, sizes[5 - i]);
			send_random(6);
		end
		// unknown index must leave everything alone
		write_reg(2'd3, 13'h1fff);
		send_random(4);
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			stall_en = (p % 3) != 0;
			write_reg(REG_CULL, DIM_W'($urandom_range(0, 1)));
			write_reg(REG_WIDTH, DIM_W'($urandom_range(1, 4096)));
			write_reg(REG_HEIGHT, DIM_W'($urandom_range(1, 4096)));
			send_random(8);
			// pause until every predicted edge is out
			drain();
			send_random(6);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		tri_in.valid = 1'b0;
		{tri_in.a_x, tri_in.a_y, tri_in.a_z} = '0;
		{tri_in.b_x, tri_in.b_y, tri_in.b_z} = '0;
		{tri_in.c_x, tri_in.c_y, tri_in.c_z} = '0;
		edge_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cull_on = 1'b0;
		scr_w = WIDTH_RST;
		scr_h = HEIGHT_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_depth();
		test_extremes();
		stall_en = 1;
		test_culling();
		test_sizes();
		test_random_traffic();

		drain();
		repeat (30) @(posedge clk);
		if (err_count == 0 && pending_edges.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
